>>> rtl/itf_pkg.sv
// Shared types, constants and helper functions of the integer text formatter.
package itf_pkg;

  localparam int VALUE_W = 64;
  localparam int OPC_W   = 3;
  localparam int FW_W    = 6;
  localparam int CHAR_W  = 8;
  localparam int DIG_W   = 4;

  localparam int DEF_MAX_FIELD_WIDTH = 63;
  localparam int DEF_VALUE_BITS      = 64;

  localparam logic [OPC_W-1:0] OP_SDEC = 3'd0;
  localparam logic [OPC_W-1:0] OP_UDEC = 3'd1;
  localparam logic [OPC_W-1:0] OP_HEX  = 3'd2;
  localparam logic [OPC_W-1:0] OP_CHAR = 3'd3;
  localparam logic [OPC_W-1:0] OP_PTR  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [VALUE_W-1:0] value;
    logic               wide;
    logic [FW_W-1:0]    field_width;
    logic               left_just;
    logic               zero_fill;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } chr_t;

  typedef struct packed {
    logic clr;
    logic conv;
    logic shift;
    logic dec;
  } dcell_ctrl_t;

  // Number of decimal digits of the largest unsigned value of the given width.
  function automatic int dec_digits(input int bits);
    dec_digits = ((bits * 1233) >> 12) + 1;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIG_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + ext;
    end else begin
      digit_char = CH_A + ext - 8'd10;
    end
  endfunction

endpackage

>>> rtl/itf_stream_if.sv
// Valid/ready stream channel that carries one item of a given payload type.
interface itf_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/itf_digit_cell.sv
// One digit cell: a double-dabble BCD or plain hex nibble stage of the digit row.
module itf_digit_cell (
  input  logic                clk_i,
  input  itf_pkg::dcell_ctrl_t ctrl_i,
  input  logic                cin_i,
  input  logic [3:0]          nbr_digit_i,
  output logic [3:0]          digit_o,
  output logic                cout_o
);
  import itf_pkg::*;

  logic [DIG_W-1:0] digit_q;
  logic [DIG_W-1:0] digit_d;
  logic [DIG_W-1:0] adj;

  always_comb begin
    if (ctrl_i.dec && (digit_q >= 4'd5)) begin
      adj = digit_q + 4'd3;
    end else begin
      adj = digit_q;
    end
  end

  always_comb begin
    priority if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[DIG_W-2:0], cin_i};
    end else if (ctrl_i.shift) begin
      digit_d = nbr_digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;
  assign cout_o  = adj[DIG_W-1];

endmodule

>>> rtl/integer_text_formatter_top.sv
// Top level of the integer text formatter: request intake, digit row and character sequencer.
//
// Usage: one request item enters on in_i (opcode, value, wide, field_width,
// left_just, zero_fill) and leaves as a run of character items on out_o,
// one ASCII character each, with last set on the final one. An unknown
// opcode is taken and yields no item.
// A new request is taken only while the sequencer is idle; in_i.ready is
// high exactly then, also while the final character still waits in the
// output register.
// Sequence: a request is accepted while the sequencer is idle. A character
// request then emits its one character. A numeric request is converted
// bit-serially, all VALUE_BITS bits through the row of digit cells; then leading
// zero digits are stripped (at most NDIG - 1, NDIG being 20 for 64-bit values),
// the padding is set, and the characters are emitted one after another.
// Stalls: when out_o.ready is low the held character stays on out_o and the
// character states of the sequencer freeze until it is taken.
// Reset: the sequencer returns to idle and the output register empties.
module integer_text_formatter_top #(
  parameter int MAX_FIELD_WIDTH = itf_pkg::DEF_MAX_FIELD_WIDTH,
  parameter int VALUE_BITS      = itf_pkg::DEF_VALUE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  itf_stream_if.sink   in_i,
  itf_stream_if.source out_o
);
  import itf_pkg::*;

  localparam int NDEC = dec_digits(VALUE_BITS);
  localparam int NHEX = (VALUE_BITS + 3) / 4;
  localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
  localparam int ND_W = $clog2(NDIG + 1);
  localparam int BC_W = $clog2(VALUE_BITS);
  localparam logic [FW_W-1:0] WMAX =
    (MAX_FIELD_WIDTH > 63) ? 6'd63 : FW_W'(MAX_FIELD_WIDTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CONV = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_PRE0 = 4'd3;
  localparam logic [3:0] S_PREX = 4'd4;
  localparam logic [3:0] S_PADL = 4'd5;
  localparam logic [3:0] S_SIGN = 4'd6;
  localparam logic [3:0] S_PADZ = 4'd7;
  localparam logic [3:0] S_DIG  = 4'd8;
  localparam logic [3:0] S_PADR = 4'd9;
  localparam logic [3:0] S_CHAR = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] sr_q, sr_d;
  logic [BC_W-1:0]       bc_q, bc_d;
  logic [ND_W-1:0]       nd_q, nd_d;
  logic [FW_W-1:0]       pad_q, pad_d;
  logic [FW_W-1:0]       width_q, width_d;
  logic                  neg_q, neg_d;
  logic                  left_q, left_d;
  logic                  zpad_q, zpad_d;
  logic                  dec_q, dec_d;
  logic                  ptr_q, ptr_d;
  logic [CHAR_W-1:0]     chr_q, chr_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_ch_q, out_ch_d;
  logic                  out_last_q, out_last_d;

  logic [DIG_W-1:0] digit_w [NDIG];
  logic             cout_w [NDIG];
  dcell_ctrl_t      cctrl;

  logic                  adv;
  logic                  emit;
  logic                  norm_done;
  logic [DIG_W-1:0]      top_dig;
  logic [6:0]            len7;
  logic [6:0]            wid7;
  logic [FW_W-1:0]       pad_calc;
  logic [VALUE_BITS-1:0] m_full, m_mask, m_val, m_neg;
  logic                  m_sign;
  logic [FW_W-1:0]       fw_clamped;
  logic                  accept;

  genvar gi;
  generate
    for (gi = 0; gi < NDIG; gi++) begin : g_cells
      logic             cin;
      logic [DIG_W-1:0] nbr;
      if (gi == 0) begin : g_lsd
        assign cin = sr_q[VALUE_BITS-1];
        assign nbr = '0;
      end else begin : g_upper
        assign cin = cout_w[gi-1];
        assign nbr = digit_w[gi-1];
      end
      itf_digit_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cctrl),
        .cin_i       (cin),
        .nbr_digit_i (nbr),
        .digit_o     (digit_w[gi]),
        .cout_o      (cout_w[gi])
      );
    end
  endgenerate

  assign top_dig   = digit_w[NDIG-1];
  assign adv       = !out_valid_q || out_o.ready;
  assign accept    = (state_q == S_IDLE) && in_i.valid;
  assign norm_done = (top_dig != '0) || (nd_q == ND_W'(1));
  assign len7      = 7'(nd_q) + {6'd0, neg_q};
  assign wid7      = {1'b0, width_q};
  assign pad_calc  = (wid7 > len7) ? FW_W'(wid7 - len7) : '0;

  assign emit = (state_q == S_PRE0) || (state_q == S_PREX) || (state_q == S_PADL) ||
                (state_q == S_SIGN) || (state_q == S_PADZ) || (state_q == S_DIG) ||
                (state_q == S_PADR) || (state_q == S_CHAR);

  always_comb begin
    m_full     = in_i.payload.value[VALUE_BITS-1:0];
    m_mask     = in_i.payload.wide ? '1 : VALUE_BITS'({32{1'b1}});
    m_val      = m_full & m_mask;
    m_sign     = in_i.payload.wide ? m_full[VALUE_BITS-1] : m_full[31];
    m_neg      = (-m_val) & m_mask;
    fw_clamped = (in_i.payload.field_width > WMAX) ? WMAX : in_i.payload.field_width;
  end

  always_comb begin
    cctrl.clr   = accept;
    cctrl.conv  = (state_q == S_CONV);
    cctrl.shift = ((state_q == S_NORM) && !norm_done) || ((state_q == S_DIG) && adv);
    cctrl.dec   = dec_q;
  end

  always_comb begin
    state_d     = state_q;
    sr_d        = sr_q;
    bc_d        = bc_q;
    nd_d        = nd_q;
    pad_d       = pad_q;
    width_d     = width_q;
    neg_d       = neg_q;
    left_d      = left_q;
    zpad_d      = zpad_q;
    dec_d       = dec_q;
    ptr_d       = ptr_q;
    chr_d       = chr_q;
    out_valid_d = out_valid_q;
    out_ch_d    = out_ch_q;
    out_last_d  = out_last_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          width_d = fw_clamped;
          left_d  = in_i.payload.left_just;
          zpad_d  = in_i.payload.zero_fill;
          neg_d   = 1'b0;
          ptr_d   = (in_i.payload.opcode == OP_PTR);
          dec_d   = (in_i.payload.opcode == OP_SDEC) || (in_i.payload.opcode == OP_UDEC);
          bc_d    = BC_W'(VALUE_BITS - 1);
          nd_d    = ND_W'(NDIG);
          chr_d   = in_i.payload.value[CHAR_W-1:0];
          unique case (in_i.payload.opcode)
            OP_SDEC: begin
              neg_d   = m_sign;
              sr_d    = m_sign ? m_neg : m_val;
              state_d = S_CONV;
            end
            OP_UDEC, OP_HEX: begin
              sr_d    = m_val;
              state_d = S_CONV;
            end
            OP_PTR: begin
              sr_d    = m_full;
              state_d = S_CONV;
            end
            OP_CHAR: begin
              state_d = S_CHAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        sr_d = {sr_q[VALUE_BITS-2:0], 1'b0};
        bc_d = bc_q - BC_W'(1);
        if (bc_q == '0) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (!norm_done) begin
          nd_d = nd_q - ND_W'(1);
        end else if (ptr_q) begin
          pad_d   = '0;
          state_d = S_PRE0;
        end else begin
          pad_d = pad_calc;
          if (left_q) begin
            state_d = neg_q ? S_SIGN : S_DIG;
          end else if (zpad_q) begin
            state_d = neg_q ? S_SIGN : ((pad_calc != '0) ? S_PADZ : S_DIG);
          end else begin
            state_d = (pad_calc != '0) ? S_PADL : (neg_q ? S_SIGN : S_DIG);
          end
        end
      end
      S_PRE0: begin
        if (adv) begin
          state_d = S_PREX;
        end
      end
      S_PREX: begin
        if (adv) begin
          state_d = S_DIG;
        end
      end
      S_PADL: begin
        if (adv) begin
          pad_d = pad_q - FW_W'(1);
          if (pad_q == FW_W'(1)) begin
            state_d = neg_q ? S_SIGN : S_DIG;
          end
        end
      end
      S_SIGN: begin
        if (adv) begin
          state_d = (!left_q && zpad_q && (pad_q != '0)) ? S_PADZ : S_DIG;
        end
      end
      S_PADZ: begin
        if (adv) begin
          pad_d = pad_q - FW_W'(1);
          if (pad_q == FW_W'(1)) begin
            state_d = S_DIG;
          end
        end
      end
      S_DIG: begin
        if (adv) begin
          nd_d = nd_q - ND_W'(1);
          if (nd_q == ND_W'(1)) begin
            state_d = (left_q && (pad_q != '0)) ? S_PADR : S_IDLE;
          end
        end
      end
      S_PADR: begin
        if (adv) begin
          pad_d = pad_q - FW_W'(1);
          if (pad_q == FW_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_CHAR: begin
        if (adv) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit && adv) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      unique case (state_q)
        S_PRE0: out_ch_d = CH_ZERO;
        S_PREX: out_ch_d = CH_X;
        S_PADL: out_ch_d = CH_SPACE;
        S_SIGN: out_ch_d = CH_MINUS;
        S_PADZ: out_ch_d = CH_ZERO;
        S_DIG: begin
          out_ch_d   = digit_char(top_dig);
          out_last_d = (nd_q == ND_W'(1)) && !(left_q && (pad_q != '0));
        end
        S_PADR: begin
          out_ch_d   = CH_SPACE;
          out_last_d = (pad_q == FW_W'(1));
        end
        default: begin
          out_ch_d   = chr_q;
          out_last_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q       <= sr_d;
    bc_q       <= bc_d;
    nd_q       <= nd_d;
    pad_q      <= pad_d;
    width_q    <= width_d;
    neg_q      <= neg_d;
    left_q     <= left_d;
    zpad_q     <= zpad_d;
    dec_q      <= dec_d;
    ptr_q      <= ptr_d;
    chr_q      <= chr_d;
    out_ch_q   <= out_ch_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = {out_ch_q, out_last_q};

endmodule
